[rtl/core/slx_pkg.sv]
package slx_pkg;

   localparam int FEATURE_COUNT  = 8;
   localparam int INTERVAL_COUNT = 256;
   localparam int MAX_LAG        = 63;

   localparam int ROW_W  = 8;
   localparam int FEAT_W = 3;
   localparam int VAL_W  = 64;
   localparam int COL_W  = 9;
   localparam int LAG_W  = 6;
   localparam int CENS_W = 9;
   localparam int LAGS_W = 48;
   localparam int CSR_W  = 48;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_CENSORING  = 1'b0,
      CSR_LAG_COUNTS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [FEAT_W-1:0] feature;
      logic [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic [VAL_W-1:0] out_value;
      logic             last;
   } rsp_type;

   // Microcode program: step numbers, jump conditions and fall-through modes.
   typedef logic [1:0] step_type;

   localparam step_type STEP_WAIT  = 2'd0;
   localparam step_type STEP_ACCUM = 2'd1;
   localparam step_type STEP_CHECK = 2'd2;
   localparam step_type STEP_EMIT  = 2'd3;

   typedef enum logic [1:0] {
      COND_ACCEPT    = 2'd0,
      COND_FEAT_DONE = 2'd1,
      COND_NO_ROWS   = 2'd2,
      COND_RUN_END   = 2'd3
   } cond_type;

   typedef enum logic [0:0] {
      MISS_STAY = 1'b0,
      MISS_NEXT = 1'b1
   } miss_type;

   typedef struct packed {
      logic     accept;
      logic     accum;
      logic     start_run;
      logic     emit;
      cond_type cond;
      step_type target;
      miss_type on_miss;
   } uword_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic feat_done;
      logic no_rows;
      logic run_end;
   } seq_stat_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      logic req_ready;
      logic load_req;
      logic accum;
      logic start_run;
      logic emit;
   } seq_ctl_type;

   function automatic uword_type ucode(input step_type step);
      uword_type w;
      w = '0;
      unique case (step)
         STEP_WAIT: begin
            w.accept  = 1'b1;
            w.cond    = COND_ACCEPT;
            w.target  = STEP_ACCUM;
            w.on_miss = MISS_STAY;
         end
         STEP_ACCUM: begin
            w.accum   = 1'b1;
            w.cond    = COND_FEAT_DONE;
            w.target  = STEP_CHECK;
            w.on_miss = MISS_STAY;
         end
         STEP_CHECK: begin
            w.start_run = 1'b1;
            w.cond      = COND_NO_ROWS;
            w.target    = STEP_WAIT;
            w.on_miss   = MISS_NEXT;
         end
         STEP_EMIT: begin
            w.emit    = 1'b1;
            w.cond    = COND_RUN_END;
            w.target  = STEP_WAIT;
            w.on_miss = MISS_STAY;
         end
      endcase
      return w;
   endfunction

   // Lag count of one feature, saturated to the largest lag allowed.
   function automatic logic [LAG_W-1:0] lag_of(input logic [LAGS_W-1:0] lags,
                                                input logic [FEAT_W-1:0] f);
      logic [LAG_W-1:0] lag;
      lag = lags[f*LAG_W +: LAG_W];
      if (lag > LAG_W'(MAX_LAG)) begin
         lag = LAG_W'(MAX_LAG);
      end
      return lag;
   endfunction

endpackage

[rtl/core/sparse_lag_expander.sv]
// Expands one sparse entry (row, feature, value) into its lagged copies
// (row+k, base+k, value) for k = 0 up to the feature's lag count, where base
// is the sum of (lag+1) over all lower features; a run stops early once row+k
// reaches the censoring limit, and the final result of each entry carries
// last. An entry whose row is at or past the limit yields no results. A
// microcoded sequencer takes the entry in, adds each lower feature's lag
// into the column base, sees that the base is complete, checks the row,
// and then loads the results into the output register in turn, holding
// while the consumer stalls. The final result waits in the output register
// while the next entry is taken in. The user must write the censoring and
// lag_counts registers only while the block is idle; the block does not enforce this.
module sparse_lag_expander (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  slx_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output slx_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  slx_pkg::csr_index_type            csr_index,
   input  logic [slx_pkg::CSR_W-1:0]         csr_wdata
);
   import slx_pkg::*;

   seq_ctl_type  ctl;
   seq_stat_type stat;

   logic [CENS_W-1:0] censoring_ff, censoring_in;
   logic [LAGS_W-1:0] lag_counts_ff, lag_counts_in;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [FEAT_W-1:0] feat_ff, feat_in;
   logic [VAL_W-1:0]  value_ff, value_in;
   logic [COL_W-1:0]  base_ff, base_in;
   logic [FEAT_W-1:0] idx_ff, idx_in;
   logic [LAG_W-1:0]  lag_ff, lag_in;
   logic [LAG_W-1:0]  k_ff, k_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [CENS_W-1:0] limit;
   logic [CENS_W:0]   next_row;
   logic              slot_free;
   logic              is_last;
   logic              rsp_load;

   slx_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // The row limit is censoring clipped to the number of intervals.
   always_comb begin
      if (censoring_ff > CENS_W'(INTERVAL_COUNT)) begin
         limit = CENS_W'(INTERVAL_COUNT);
      end else begin
         limit = censoring_ff;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign next_row  = (CENS_W+1)'(row_ff) + (CENS_W+1)'(k_ff) + (CENS_W+1)'(1);
   assign is_last   = (k_ff == lag_ff) || (next_row >= (CENS_W+1)'(limit));
   assign rsp_load  = ctl.emit && slot_free;

   always_comb begin
      stat.req_valid = req_valid;
      stat.feat_done = (idx_ff == feat_ff);
      stat.no_rows   = ((CENS_W)'(row_ff) >= limit) ||
                       ((FEAT_W+1)'(feat_ff) >= (FEAT_W+1)'(FEATURE_COUNT));
      stat.run_end   = slot_free && is_last;
   end

   always_comb begin
      censoring_in  = censoring_ff;
      lag_counts_in = lag_counts_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CENSORING:  censoring_in  = csr_wdata[CENS_W-1:0];
            CSR_LAG_COUNTS: lag_counts_in = csr_wdata[LAGS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      row_in   = row_ff;
      feat_in  = feat_ff;
      value_in = value_ff;
      base_in  = base_ff;
      idx_in   = idx_ff;
      lag_in   = lag_ff;
      k_in     = k_ff;
      if (ctl.load_req) begin
         row_in   = req_data.row;
         feat_in  = req_data.feature;
         value_in = req_data.value;
         base_in  = '0;
         idx_in   = '0;
      end
      if (ctl.accum) begin
         base_in = base_ff + COL_W'(lag_of(lag_counts_ff, idx_ff)) + COL_W'(1);
         idx_in  = idx_ff + FEAT_W'(1);
      end
      if (ctl.start_run) begin
         lag_in = lag_of(lag_counts_ff, feat_ff);
         k_in   = '0;
      end
      if (rsp_load) begin
         k_in = k_ff + LAG_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.out_row   = row_ff + ROW_W'(k_ff);
         rsp_in.out_col   = base_ff + COL_W'(k_ff);
         rsp_in.out_value = value_ff;
         rsp_in.last      = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         censoring_ff  <= CENS_W'(256);
         lag_counts_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         censoring_ff  <= censoring_in;
         lag_counts_ff <= lag_counts_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      feat_ff  <= feat_in;
      value_ff <= value_in;
      base_ff  <= base_in;
      idx_ff   <= idx_in;
      lag_ff   <= lag_in;
      k_ff     <= k_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = ctl.req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Every emitted row lies below the limit.
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> ((CENS_W)'(row_ff) + (CENS_W)'(k_ff) < limit))
      else $error("result row at or past the limit");

   // A result without last never ends the lag run.
   a_not_last_in_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !is_last) |-> (k_ff < lag_ff))
      else $error("run continued past the lag count");

   // A new transaction is never taken while a run is emitting.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !rsp_load)
      else $error("input taken during a run");

   // Consecutive results of one run step the column by one.
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !is_last) ##1 rsp_load |->
         (rsp_in.out_col == $past(rsp_in.out_col) + COL_W'(1)))
      else $error("column did not advance within a run");

endmodule

[rtl/core/slx_seq.sv]
module slx_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  slx_pkg::seq_stat_type stat,
   output slx_pkg::seq_ctl_type  ctl
);
   import slx_pkg::*;

   step_type  step_ff;
   step_type  step_in;
   uword_type word;
   logic      hit;

   assign word = ucode(step_ff);

   always_comb begin
      unique case (word.cond)
         COND_ACCEPT:    hit = stat.req_valid;
         COND_FEAT_DONE: hit = stat.feat_done;
         COND_NO_ROWS:   hit = stat.no_rows;
         COND_RUN_END:   hit = stat.run_end;
         default:        hit = 1'b0;
      endcase
   end

   always_comb begin
      if (hit) begin
         step_in = word.target;
      end else if (word.on_miss == MISS_NEXT) begin
         step_in = step_ff + step_type'(1);
      end else begin
         step_in = step_ff;
      end
   end

   always_comb begin
      ctl.req_ready = word.accept;
      ctl.load_req  = word.accept && stat.req_valid;
      ctl.accum     = word.accum && !stat.feat_done;
      ctl.start_run = word.start_run && !stat.no_rows;
      ctl.emit      = word.emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   // A transaction taken in the wait step always leads to the accumulate step.
   a_accum_after_accept: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_WAIT && stat.req_valid) |=> (step_ff == STEP_ACCUM))
      else $error("sequencer did not leave the wait step on a transaction");

   // A finished run always returns to the wait step.
   a_run_end_returns: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_EMIT && stat.run_end) |=> (step_ff == STEP_WAIT))
      else $error("sequencer did not return to wait after the last result");

   // The emit step is only reached through the row check.
   a_emit_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(step_ff == STEP_EMIT) |-> ($past(step_ff) == STEP_CHECK))
      else $error("emit step entered from the wrong step");

endmodule
